// ===== sv/bde_pkg.sv =====
`default_nettype none

package bde_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
  localparam logic REG_DEBOUNCE = 1'b0;

  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] button;
  } ev_t;

  typedef struct packed {
    logic scan;
    logic clear;
  } btn_cmd_t;

endpackage

`default_nettype wire

// ===== sv/button_debounce_event_queue.sv =====
// Debounced button bank with a press/release event queue.
// Request channel: in_valid/in_ready carry opcode, button_levels, now_ms and
// button_index. Result channel: out_valid/out_ready carry event_valid,
// event_kind, event_button, clicked and stable_levels; every request gives
// exactly one result.
// A scan visits the buttons one per cycle through a single 32-bit subtract
// and compare unit. A pop passes through S_POP and S_POP_DATA, the latter
// waiting on the registered read of the event memory, and skips S_POP_DATA
// when the queue is empty; a query passes through S_QUERY, and an unused
// opcode goes straight to S_FINISH.
// in_ready is low while a request is being worked on. A finished result sits
// in the output register; if out_ready is low the block holds the next
// result until the register frees, and takes no new request meanwhile.
// Configuration (APB, register 0 debounce_ms at address 0): the user must
// write it only while the block is idle, unenforced; pready is always high.
// Reset is synchronous: it clears every button's state, empties the event
// queue, drops a pending result and loads debounce_ms with 20. The event
// memory needs no clearing pass.
`default_nettype none

module button_debounce_event_queue #(
  parameter int unsigned BUTTONS    = 4,
  parameter int unsigned RING_DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 opcode,
  input  wire logic [3:0]                 button_levels,
  input  wire logic [31:0]                now_ms,
  input  wire logic [1:0]                 button_index,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            event_valid,
  output logic                            event_kind,
  output logic [1:0]                      event_button,
  output logic                            clicked,
  output logic [3:0]                      stable_levels,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bde_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import bde_pkg::*;

  localparam int unsigned IW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam logic [IW-1:0] SEL_LAST = IW'(BUTTONS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POP,
    S_POP_DATA,
    S_QUERY,
    S_FINISH
  } state_t;

  state_t             state;
  logic [IW-1:0]      sel;
  logic [3:0]         levels_q;
  logic [31:0]        now_q;
  logic [1:0]         index_q;
  logic               res_valid;
  logic               res_kind;
  logic [1:0]         res_button;
  logic               res_clicked;
  logic [15:0]        debounce_ms;

  logic [BUTTONS-1:0] levels_ext;
  logic [BUTTONS-1:0] stable_vec;
  logic [3:0]         stable_mask;
  logic               index_ok;
  logic               click;
  logic               push;
  ev_t                push_ev;
  logic               ring_empty;
  ev_t                rd_ev;
  btn_cmd_t           cmd;
  logic               ring_pop;
  logic               cfg_write;

  for (genvar gi = 0; gi < BUTTONS; gi++) begin : g_levels
    if (gi < 4) begin : g_in
      assign levels_ext[gi] = levels_q[gi];
    end else begin : g_zero
      assign levels_ext[gi] = 1'b0;
    end
  end

  for (genvar gi = 0; gi < 4; gi++) begin : g_mask
    if (gi < BUTTONS) begin : g_in
      assign stable_mask[gi] = stable_vec[gi];
    end else begin : g_zero
      assign stable_mask[gi] = 1'b0;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign index_ok  = (32'(index_q) < BUTTONS);
  assign cmd.scan  = (state == S_SCAN);
  assign cmd.clear = (state == S_QUERY) && index_ok;
  assign ring_pop  = (state == S_POP);

  bde_buttons #(
    .BUTTONS (BUTTONS),
    .IW      (IW)
  ) u_buttons (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sel      (sel),
    .sample   (levels_ext[sel]),
    .now      (now_q),
    .debounce (debounce_ms),
    .stable   (stable_vec),
    .click    (click),
    .push     (push),
    .push_ev  (push_ev)
  );

  bde_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_ev (push_ev),
    .pop     (ring_pop),
    .empty   (ring_empty),
    .rd_ev   (rd_ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            levels_q    <= button_levels;
            now_q       <= now_ms;
            index_q     <= button_index;
            res_valid   <= 1'b0;
            res_kind    <= 1'b0;
            res_button  <= '0;
            res_clicked <= 1'b0;
            case (opcode)
              OP_SCAN: begin
                sel   <= '0;
                state <= S_SCAN;
              end
              OP_POP: begin
                state <= S_POP;
              end
              OP_QUERY: begin
                sel   <= IW'(button_index);
                state <= S_QUERY;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (sel == SEL_LAST) begin
            state <= S_FINISH;
          end else begin
            sel <= sel + 1'b1;
          end
        end
        S_POP: begin
          state <= ring_empty ? S_FINISH : S_POP_DATA;
        end
        S_POP_DATA: begin
          res_valid  <= 1'b1;
          res_kind   <= rd_ev.kind;
          res_button <= rd_ev.button;
          state      <= S_FINISH;
        end
        S_QUERY: begin
          res_clicked <= index_ok && click;
          state       <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            event_valid   <= res_valid;
            event_kind    <= res_kind;
            event_button  <= res_button;
            clicked       <= res_clicked;
            stable_levels <= stable_mask;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_DEBOUNCE) ? {16'd0, debounce_ms} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
    end else if (cfg_write && paddr[2] == REG_DEBOUNCE) begin
      debounce_ms <= pwdata[15:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/bde_ring.sv =====
`default_nettype none

module bde_ring #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire bde_pkg::ev_t push_ev,
  input  wire logic         pop,
  output logic              empty,
  output bde_pkg::ev_t      rd_ev
);
  import bde_pkg::*;

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);

  ev_t           mem [RING_DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] head_next;
  logic [PW-1:0] tail_next;
  logic          full;

  assign head_next = (head == PTR_LAST) ? '0 : head + 1'b1;
  assign tail_next = (tail == PTR_LAST) ? '0 : tail + 1'b1;
  assign full      = (head_next == tail);
  assign empty     = (head == tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (push && !full) begin
        head <= head_next;
      end
      if (pop && !empty) begin
        tail <= tail_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[head] <= push_ev;
    end
    rd_ev <= mem[tail];
  end

endmodule

`default_nettype wire

// ===== sv/bde_buttons.sv =====
`default_nettype none

module bde_buttons #(
  parameter int unsigned BUTTONS = 4,
  parameter int unsigned IW      = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bde_pkg::btn_cmd_t cmd,
  input  wire logic [IW-1:0]     sel,
  input  wire logic              sample,
  input  wire logic [31:0]       now,
  input  wire logic [15:0]       debounce,
  output logic [BUTTONS-1:0]     stable,
  output logic                   click,
  output logic                   push,
  output bde_pkg::ev_t           push_ev
);
  import bde_pkg::*;

  logic [BUTTONS-1:0] sampled;
  logic [BUTTONS-1:0] clicks;
  logic [31:0]        last_change [BUTTONS];
  logic [31:0]        elapsed;
  logic               cur_sample;
  logic               changed;
  logic               settle;

  assign cur_sample = sampled[sel];
  assign elapsed    = now - last_change[sel];
  assign changed    = (sample != cur_sample);
  assign settle     = !changed && (elapsed >= {16'd0, debounce})
                      && (stable[sel] != cur_sample);

  assign click          = clicks[sel];
  assign push           = cmd.scan && settle;
  assign push_ev.kind   = cur_sample;
  assign push_ev.button = 2'(sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      sampled <= '0;
      stable  <= '0;
      clicks  <= '0;
      for (int i = 0; i < BUTTONS; i++) begin
        last_change[i] <= '0;
      end
    end else begin
      if (cmd.scan) begin
        if (changed) begin
          sampled[sel]     <= sample;
          last_change[sel] <= now;
        end else if (settle) begin
          stable[sel] <= cur_sample;
          if (cur_sample) begin
            clicks[sel] <= 1'b1;
          end
        end
      end
      if (cmd.clear) begin
        clicks[sel] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/bde_chk.sv =====
`default_nettype none

module bde_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       event_valid,
  input wire logic       event_kind,
  input wire logic [1:0] event_button,
  input wire logic       clicked
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_valid |-> !event_kind && event_button == 2'd0)
    else $error("event fields set without an event");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(event_valid && clicked))
    else $error("pop and query results mixed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result left after reset");

endmodule

bind button_debounce_event_queue bde_chk u_bde_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .event_valid  (event_valid),
  .event_kind   (event_kind),
  .event_button (event_button),
  .clicked      (clicked)
);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bde_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] DEBOUNCE_ADDR = ADDR_W'(4 * REG_DEBOUNCE);
  localparam int EVENT_SLOTS = 15;
  localparam int QUIET_LIMIT = 4000;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  levels;
    logic [31:0] now;
    logic [1:0]  idx;
  } key_req_t;

  typedef struct packed {
    logic       ev_valid;
    logic       ev_kind;
    logic [1:0] ev_button;
    logic       was_clicked;
    logic [3:0] stable;
  } key_result_t;

  typedef struct packed {
    key_req_t    req;
    logic        typed;
    key_result_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [3:0]  button_levels = '0;
  logic [31:0] now_ms = '0;
  logic [1:0]  button_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        event_valid;
  logic        event_kind;
  logic [1:0]  event_button;
  logic        clicked;
  logic [3:0]  stable_levels;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  button_debounce_event_queue u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .button_levels(button_levels), .now_ms(now_ms),
    .button_index(button_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_valid(event_valid), .event_kind(event_kind), .event_button(event_button),
    .clicked(clicked), .stable_levels(stable_levels),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [3:0]  raw_seen;
  logic [3:0]  debounced;
  logic [3:0]  click_flags;
  logic [31:0] change_at [4];
  logic [15:0] hold_ms;
  ev_t         pending_events [$];
  key_result_t expected_results [$];

  int send_idle = 33;
  int recv_idle = 55;
  int mismatches = 0;
  int quiet_cycles = 0;
  logic [31:0] tick_ms;
  logic [3:0]  raw_drive;
  dir_row_t    directed_rows [DIRECTED_ROWS];

  function automatic key_result_t predict_key_request(input key_req_t r);
    key_result_t res;
    logic [31:0] held;
    res = '0;
    case (r.op)
      OP_SCAN: begin
        for (int i = 0; i < 4; i++) begin
          held = r.now - change_at[i];
          if (r.levels[i] != raw_seen[i]) begin
            raw_seen[i] = r.levels[i];
            change_at[i] = r.now;
          end else if (held >= {16'd0, hold_ms} && debounced[i] != raw_seen[i]) begin
            debounced[i] = raw_seen[i];
            if (debounced[i]) click_flags[i] = 1'b1;
            if (pending_events.size() < EVENT_SLOTS)
              pending_events.push_back('{kind: debounced[i], button: 2'(i)});
          end
        end
      end
      OP_POP: begin
        if (pending_events.size() != 0) begin
          res.ev_valid = 1'b1;
          res.ev_kind = pending_events[0].kind;
          res.ev_button = pending_events[0].button;
          void'(pending_events.pop_front());
        end
      end
      OP_QUERY: begin
        res.was_clicked = click_flags[r.idx];
        click_flags[r.idx] = 1'b0;
      end
      default: ;
    endcase
    res.stable = debounced;
    return res;
  endfunction

  function automatic dir_row_t dir_row(input logic [1:0] op, input logic [3:0] levels,
                                       input logic [31:0] now, input logic [1:0] idx,
                                       input logic typed, input logic [8:0] want);
    dir_row_t row;
    row.req = '{op: op, levels: levels, now: now, idx: idx};
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  task automatic issue_request(input key_req_t r, input logic typed, input key_result_t want);
    key_result_t pred;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= r.op;
    button_levels <= r.levels;
    now_ms <= r.now;
    button_index <= r.idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_key_request(r);
    expected_results.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_hold(input logic [15:0] ms);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DEBOUNCE_ADDR;
    pwdata <= {16'($urandom), ms};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    hold_ms = ms;
  endtask

  task automatic run_phase(input int count, input int pop_pct);
    key_req_t r;
    int pick;
    int unsigned d;
    int unsigned step;
    tick_ms = $urandom;
    for (int n = 0; n < count; n++) begin
      d = hold_ms;
      pick = $urandom_range(0, 99);
      r.levels = 4'($urandom);
      r.now = $urandom;
      r.idx = 2'($urandom);
      if (pick < 60) begin
        r.op = OP_SCAN;
        pick = $urandom_range(0, 99);
        if (pick < 35) raw_drive ^= 4'($urandom_range(1, 15));
        else if (pick < 45) raw_drive = 4'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55) step = $urandom_range(0, d / 3 + 1);
        else if (pick < 90) step = $urandom_range(d / 2, d + d / 4 + 2);
        else step = $urandom;
        tick_ms += step;
        r.levels = raw_drive;
        r.now = tick_ms;
      end else if (pick < 60 + pop_pct) begin
        r.op = OP_POP;
      end else if (pick < 96) begin
        r.op = OP_QUERY;
      end else begin
        r.op = OP_UNUSED;
      end
      issue_request(r, 1'b0, '0);
    end
  endtask

  // check results, stall the receiver
  always @(posedge clk) begin
    key_result_t got;
    key_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{event_valid, event_kind, event_button, clicked, stable_levels};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: valid=%0d kind=%0d button=%0d clicked=%0d stable=%h",
                   got.ev_valid, got.ev_kind, got.ev_button, got.was_clicked, got.stable);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want valid=%0d kind=%0d button=%0d clicked=%0d stable=%h, %s",
                     want.ev_valid, want.ev_kind, want.ev_button, want.was_clicked,
                     want.stable,
                     $sformatf("got valid=%0d kind=%0d button=%0d clicked=%0d stable=%h",
                               got.ev_valid, got.ev_kind, got.ev_button, got.was_clicked,
                               got.stable));
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    raw_seen = '0;
    debounced = '0;
    click_flags = '0;
    for (int i = 0; i < 4; i++) change_at[i] = '0;
    hold_ms = DEBOUNCE_RESET;
    raw_drive = '0;
    tick_ms = '0;

    directed_rows = '{
      dir_row(OP_POP,    4'h0, 32'd0,        2'd0, 1'b1, 9'b0_0_00_0_0000),
      dir_row(OP_QUERY,  4'h0, 32'd0,        2'd0, 1'b1, 9'b0_0_00_0_0000),
      dir_row(OP_UNUSED, 4'hF, 32'hFFFFFFFF, 2'd3, 1'b1, 9'b0_0_00_0_0000),
      dir_row(OP_SCAN,   4'hF, 32'd100,      2'd0, 1'b1, 9'b0_0_00_0_0000),
      dir_row(OP_SCAN,   4'hF, 32'd119,      2'd0, 1'b1, 9'b0_0_00_0_0000),
      dir_row(OP_SCAN,   4'hF, 32'd120,      2'd0, 1'b1, 9'b0_0_00_0_1111),
      dir_row(OP_QUERY,  4'h0, 32'd0,        2'd0, 1'b1, 9'b0_0_00_1_1111),
      dir_row(OP_QUERY,  4'h0, 32'd0,        2'd0, 1'b1, 9'b0_0_00_0_1111),
      dir_row(OP_POP,    4'h0, 32'd0,        2'd0, 1'b1, 9'b1_1_00_0_1111),
      dir_row(OP_POP,    4'h0, 32'd0,        2'd0, 1'b1, 9'b1_1_01_0_1111),
      dir_row(OP_SCAN,   4'h0, 32'd200,      2'd0, 1'b1, 9'b0_0_00_0_1111),
      dir_row(OP_SCAN,   4'h0, 32'hFFFFFFF0, 2'd0, 1'b1, 9'b0_0_00_0_0000),
      dir_row(OP_SCAN,   4'h5, 32'hFFFFFFF8, 2'd0, 1'b1, 9'b0_0_00_0_0000),
      dir_row(OP_SCAN,   4'h5, 32'h0000000B, 2'd0, 1'b1, 9'b0_0_00_0_0000),
      dir_row(OP_SCAN,   4'h5, 32'h0000000C, 2'd0, 1'b1, 9'b0_0_00_0_0101),
      dir_row(OP_QUERY,  4'hF, 32'hFFFFFFFF, 2'd3, 1'b0, 9'b0),
      dir_row(OP_QUERY,  4'h0, 32'd0,        2'd2, 1'b0, 9'b0),
      dir_row(OP_POP,    4'hF, 32'hFFFFFFFF, 2'd3, 1'b0, 9'b0),
      dir_row(OP_POP,    4'h0, 32'd0,        2'd0, 1'b0, 9'b0),
      dir_row(OP_SCAN,   4'hA, 32'h00000010, 2'd1, 1'b0, 9'b0),
      dir_row(OP_SCAN,   4'h5, 32'h00000011, 2'd2, 1'b0, 9'b0),
      dir_row(OP_QUERY,  4'h0, 32'd0,        2'd1, 1'b0, 9'b0),
      dir_row(OP_UNUSED, 4'h0, 32'd0,        2'd0, 1'b0, 9'b0),
      dir_row(OP_SCAN,   4'h5, 32'h80000000, 2'd3, 1'b0, 9'b0),
      dir_row(OP_POP,    4'h0, 32'd0,        2'd0, 1'b0, 9'b0)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < DIRECTED_ROWS; n++)
      issue_request(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);

    drain_results();
    program_hold(16'd0);
    run_phase(150, 22);
    drain_results();
    program_hold(16'hFFFF);
    run_phase(150, 22);

    send_idle = 55;
    recv_idle = 33;
    drain_results();
    program_hold(16'd7);
    run_phase(170, 4);
    drain_results();
    program_hold(16'd1);
    run_phase(150, 30);

    send_idle = 0;
    recv_idle = 0;
    drain_results();
    program_hold(16'($urandom_range(2, 300)));
    run_phase(160, 22);
    drain_results();
    program_hold(DEBOUNCE_RESET);
    run_phase(170, 22);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
